// ===== rtl/connection_slot_table_macros.svh =====
// ----------------------------------------------------------------------------
// connection_slot_table_macros.svh
// Assertion macros for the connection slot table. They expand to concurrent
// assertions on clk with arst_n as the disable, or to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_TABLE_MACROS_SVH
`define CONNECTION_SLOT_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition in the same cycle as its trigger.
`define CST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("connection_slot_table: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define CST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("connection_slot_table: next-cycle check failed");

`else

`define CST_ASSERT_IMP(label, ante, cons)
`define CST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, operation codes and the controller/datapath command and
// status structs of the connection slot table.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int SLOT_COUNT_DEF = 8;

	typedef logic [1:0]  mode_t;
	typedef logic [11:0] handle_t;
	typedef logic [7:0]  atype_t;
	typedef logic [47:0] addr_t;
	typedef logic [2:0]  slot_t;

	// Item operations
	localparam mode_t MODE_LOOKUP   = 2'd0;
	localparam mode_t MODE_ALLOCATE = 2'd1;
	localparam mode_t MODE_FREE     = 2'd2;
	localparam mode_t MODE_COMPACT  = 2'd3;

	// Result staging operations
	typedef logic [2:0] res_op_t;
	localparam res_op_t RES_NONE  = 3'd0;
	localparam res_op_t RES_MISS  = 3'd1;
	localparam res_op_t RES_SLOT  = 3'd2;
	localparam res_op_t RES_FOUND = 3'd3;
	localparam res_op_t RES_DONE  = 3'd4;

	// Valid flag operations
	typedef logic [1:0] val_op_t;
	localparam val_op_t VAL_NONE    = 2'd0;
	localparam val_op_t VAL_SET_IDX = 2'd1;
	localparam val_op_t VAL_CLR_IDX = 2'd2;
	localparam val_op_t VAL_MOVE    = 2'd3;

	// Entry memory write operations
	typedef logic [1:0] wr_op_t;
	localparam wr_op_t WR_NONE = 2'd0;
	localparam wr_op_t WR_ITEM = 2'd1;
	localparam wr_op_t WR_MOVE = 2'd2;

	typedef struct packed {
		handle_t handle;
		atype_t  atype;
		addr_t   addr;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		logic    idx_inc;
		logic    wp_inc;
		val_op_t val_op;
		wr_op_t  wr_op;
		res_op_t res_op;
		logic    publish;
	} cst_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  handle_zero;
		logic  cur_valid;
		logic  hit;
		logic  last;
		logic  wp_eq_idx;
	} cst_sts_t;

endpackage

// ===== rtl/cst_ctrl.sv =====
// ----------------------------------------------------------------------------
// cst_ctrl
// Operation sequencer: walks the slot index, orders memory reads and writes,
// stages the result and owns both handshakes.
// ----------------------------------------------------------------------------
module cst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cst_pkg::cst_sts_t sts,
	output cst_pkg::cst_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_READ     = 3'd2;
	localparam logic [2:0] ST_CHECK    = 3'd3;
	localparam logic [2:0] ST_ALLOC    = 3'd4;
	localparam logic [2:0] ST_CSCAN    = 3'd5;
	localparam logic [2:0] ST_CMOVE    = 3'd6;
	localparam logic [2:0] ST_FINISH   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.mode)
					cst_pkg::MODE_LOOKUP: state_d = ST_READ;
					cst_pkg::MODE_ALLOCATE: state_d = ST_ALLOC;
					cst_pkg::MODE_FREE: begin
						if (sts.handle_zero) begin
							cmd.res_op = cst_pkg::RES_MISS;
							state_d    = ST_FINISH;
						end else begin
							state_d = ST_READ;
						end
					end
					cst_pkg::MODE_COMPACT: state_d = ST_CSCAN;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.hit) begin
					if (sts.mode == cst_pkg::MODE_LOOKUP) begin
						cmd.res_op = cst_pkg::RES_FOUND;
					end else begin
						cmd.res_op = cst_pkg::RES_SLOT;
						cmd.val_op = cst_pkg::VAL_CLR_IDX;
					end
					state_d = ST_FINISH;
				end else if (sts.last) begin
					cmd.res_op = cst_pkg::RES_MISS;
					state_d    = ST_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_ALLOC: begin
				if (!sts.cur_valid) begin
					cmd.wr_op  = cst_pkg::WR_ITEM;
					cmd.val_op = cst_pkg::VAL_SET_IDX;
					cmd.res_op = cst_pkg::RES_SLOT;
					state_d    = ST_FINISH;
				end else if (sts.last) begin
					cmd.res_op = cst_pkg::RES_MISS;
					state_d    = ST_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_CSCAN: begin
				if (sts.cur_valid && !sts.wp_eq_idx) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CMOVE;
				end else begin
					cmd.wp_inc = sts.cur_valid;
					if (sts.last) begin
						cmd.res_op = cst_pkg::RES_DONE;
						state_d    = ST_FINISH;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_CMOVE: begin
				cmd.wr_op  = cst_pkg::WR_MOVE;
				cmd.val_op = cst_pkg::VAL_MOVE;
				cmd.wp_inc = 1'b1;
				if (sts.last) begin
					cmd.res_op = cst_pkg::RES_DONE;
					state_d    = ST_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_CSCAN;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/cst_datapath.sv =====
// ----------------------------------------------------------------------------
// cst_datapath
// Slot storage and scan datapath: valid flags, entry memory with registered
// read, scan and write pointers, item registers, result and output registers.
// ----------------------------------------------------------------------------
module cst_datapath #(
	parameter int SLOT_COUNT = cst_pkg::SLOT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cst_pkg::cst_cmd_t  cmd,
	output cst_pkg::cst_sts_t  sts,
	input  cst_pkg::mode_t     mode,
	input  cst_pkg::handle_t   conn_handle,
	input  cst_pkg::atype_t    peer_addr_type,
	input  cst_pkg::addr_t     peer_addr,
	output logic               ok,
	output cst_pkg::slot_t     slot,
	output cst_pkg::atype_t    found_addr_type,
	output cst_pkg::addr_t     found_addr
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	cst_pkg::mode_t   mode_q;
	cst_pkg::handle_t handle_q;
	cst_pkg::atype_t  atype_q;
	cst_pkg::addr_t   addr_q;

	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      wp_q;
	logic [SLOT_COUNT-1:0] valid_q;

	cst_pkg::entry_t mem_q [SLOT_COUNT];
	cst_pkg::entry_t rd_data_s1;

	logic             res_ok_q;
	cst_pkg::slot_t   res_slot_q;
	cst_pkg::atype_t  res_atype_q;
	cst_pkg::addr_t   res_addr_q;

	logic             ok_q;
	cst_pkg::slot_t   slot_q;
	cst_pkg::atype_t  found_atype_q;
	cst_pkg::addr_t   found_addr_q;

	assign sts.mode        = mode_q;
	assign sts.handle_zero = (handle_q == '0);
	assign sts.cur_valid   = valid_q[idx_q];
	assign sts.hit         = valid_q[idx_q] && (rd_data_s1.handle == handle_q);
	assign sts.last        = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign sts.wp_eq_idx   = (wp_q == idx_q);

	assign ok              = ok_q;
	assign slot            = slot_q;
	assign found_addr_type = found_atype_q;
	assign found_addr      = found_addr_q;

	// Pointers and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			wp_q    <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				wp_q  <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.wp_inc) begin
					wp_q <= wp_q + 1'b1;
				end
			end
			case (cmd.val_op)
				cst_pkg::VAL_SET_IDX: valid_q[idx_q] <= 1'b1;
				cst_pkg::VAL_CLR_IDX: valid_q[idx_q] <= 1'b0;
				cst_pkg::VAL_MOVE: begin
					valid_q[wp_q]  <= 1'b1;
					valid_q[idx_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		case (cmd.wr_op)
			cst_pkg::WR_ITEM: mem_q[idx_q] <= '{handle: handle_q, atype: atype_q, addr: addr_q};
			cst_pkg::WR_MOVE: mem_q[wp_q] <= rd_data_s1;
			default: ;
		endcase
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[idx_q];
		end
	end

	// Item, result staging and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			handle_q <= conn_handle;
			atype_q  <= peer_addr_type;
			addr_q   <= peer_addr;
		end
		case (cmd.res_op)
			cst_pkg::RES_MISS: begin
				res_ok_q    <= 1'b0;
				res_slot_q  <= '0;
				res_atype_q <= '0;
				res_addr_q  <= '0;
			end
			cst_pkg::RES_SLOT: begin
				res_ok_q    <= 1'b1;
				res_slot_q  <= cst_pkg::slot_t'(idx_q);
				res_atype_q <= '0;
				res_addr_q  <= '0;
			end
			cst_pkg::RES_FOUND: begin
				res_ok_q    <= 1'b1;
				res_slot_q  <= cst_pkg::slot_t'(idx_q);
				res_atype_q <= rd_data_s1.atype;
				res_addr_q  <= rd_data_s1.addr;
			end
			cst_pkg::RES_DONE: begin
				res_ok_q    <= 1'b1;
				res_slot_q  <= '0;
				res_atype_q <= '0;
				res_addr_q  <= '0;
			end
			default: ;
		endcase
		if (cmd.publish) begin
			ok_q          <= res_ok_q;
			slot_q        <= res_slot_q;
			found_atype_q <= res_atype_q;
			found_addr_q  <= res_addr_q;
		end
	end

endmodule

// ===== rtl/connection_slot_table.sv =====
// ----------------------------------------------------------------------------
// connection_slot_table
// Table of SLOT_COUNT connection slots, each with a valid flag, a 12-bit
// connection handle, an 8-bit peer address type and a 48-bit peer address.
// Every accepted item runs one operation and returns exactly one result item:
// lookup reports the lowest valid slot with a matching handle and its
// address; allocate fills the lowest free slot (ok low when full); free
// releases the lowest slot holding the handle and refuses handle zero;
// compact moves the valid slots to the front in their original order.
// Slot numbers come out in three bits. Reset empties the table at once.
// The block works on one item at a time: it takes an item only while idle
// and walks the slots one by one. Lookup and free read each slot through the
// single read port of the entry memory and then check it; allocate tests
// each slot's valid flag; compact scans each slot and reads and moves each
// valid slot that is not yet in place. A free of handle zero skips the walk.
// A finished result waits in the output register while out_stall is high;
// the walk of the next item holds at its end until that register is free.
// ----------------------------------------------------------------------------
`include "connection_slot_table_macros.svh"

module connection_slot_table #(
	parameter int SLOT_COUNT = cst_pkg::SLOT_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,

	// Item channel
	input  logic             in_valid,
	output logic             in_stall,
	input  cst_pkg::mode_t   mode,
	input  cst_pkg::handle_t conn_handle,
	input  cst_pkg::atype_t  peer_addr_type,
	input  cst_pkg::addr_t   peer_addr,

	// Result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic             ok,
	output cst_pkg::slot_t   slot,
	output cst_pkg::atype_t  found_addr_type,
	output cst_pkg::addr_t   found_addr
);

	cst_pkg::cst_cmd_t cmd;
	cst_pkg::cst_sts_t sts;

	// Sequencer: decode the operation, step the scan, hand off the result
	cst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and compare: valid flags, entry memory, pointers, result
	cst_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.conn_handle     (conn_handle),
		.peer_addr_type  (peer_addr_type),
		.peer_addr       (peer_addr),
		.ok              (ok),
		.slot            (slot),
		.found_addr_type (found_addr_type),
		.found_addr      (found_addr)
	);

	// The block goes busy right after it takes an item
	`CST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A failed operation reports slot zero and no address
	`CST_ASSERT_IMP(a_miss_clean, out_valid && !ok, {slot, found_addr_type, found_addr} == '0)

	// A compaction move never copies a slot onto itself
	`CST_ASSERT_IMP(a_move_distinct, cmd.wr_op == cst_pkg::WR_MOVE, !sts.wp_eq_idx)

	// A new result only lands in a free or draining output register
	`CST_ASSERT_IMP(a_publish_free, cmd.publish, !out_valid || !out_stall)

endmodule
